### rtl/utc_pkg.sv
// Package for the unicycle tracking controller: payload structs, register
// indexes, fixed-point constants and the controller-to-datapath command types.
// No dependencies.
package utc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] REG_MODE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GAIN_X = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GAIN_Y = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_GAIN_HEADING = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DB_VX = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DB_VY = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_DB_TURN = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;

  localparam logic [1:0] KIND_POSE = 2'd0;
  localparam logic [1:0] KIND_TARGET = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_PASS = 2'd1;
  localparam logic [1:0] MODE_LAW = 2'd2;
  localparam logic [1:0] MODE_LAW_ALT = 2'd3;

  localparam logic [17:0] SIN_A = 18'd102944;
  localparam logic [17:0] SIN_B = 18'd42048;
  localparam logic [17:0] SIN_C = 18'd4640;

  typedef struct packed {
    logic [1:0] kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0] heading;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] turn_rate;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] cmd_speed;
    logic signed [31:0] cmd_turn;
    logic signed [31:0] err_x;
    logic signed [31:0] err_y;
    logic [15:0] err_heading;
  } out_word_t;

  // Datapath operations, one per controller step.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,      // latch the tick operands, start sine of the heading
    OP_SIN_STEP,  // one stage of the shared sine polynomial
    OP_SIN_SAVE,  // store the finished sine into a slot
    OP_MUL,       // product a*b into the accumulator
    OP_SQRT,      // one bit of the integer square root
    OP_FINISH     // assemble the result word
  } op_t;

  typedef struct packed {
    op_t op;
    logic [3:0] sel;  // operand / slot selector
    logic [2:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic dummy;
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -66'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

endpackage

### rtl/utc_datapath.sv
// Datapath of the unicycle tracking controller: state registers, a shared
// 33x33 multiplier with a registered product, sine polynomial and square root.
// Depends on utc_pkg.
module utc_datapath (
  input  logic                clk,
  input  utc_pkg::dp_cmd_t    cmd,
  input  logic                upd,
  input  utc_pkg::in_word_t   in_word,
  input  logic [1:0]          mode,
  input  logic signed [31:0]  gain_x,
  input  logic signed [31:0]  gain_y,
  input  logic signed [31:0]  gain_heading,
  input  logic [30:0]         db_vx,
  input  logic [30:0]         db_vy,
  input  logic [30:0]         db_turn,
  input  logic                rst,
  output utc_pkg::out_word_t  res
);

  localparam logic [17:0] SIN_C_EXT = utc_pkg::SIN_C;

  logic signed [31:0] meas_x, meas_y, tgt_x, tgt_y, tgt_vx, tgt_vy, tgt_turn;
  logic [15:0] meas_heading, tgt_heading;

  // Sine slots: 0 sin(mh), 1 cos(mh), 2 sin(eh), 3 cos(eh).
  logic signed [17:0] trig [4];
  logic [17:0] z, z2, t;
  logic [15:0] ang;
  logic [63:0] sq, rem, root, bitv;
  logic signed [31:0] ex, ey, v, pvy;
  logic signed [66:0] acc, prod;
  logic signed [32:0] ma, mb;
  logic signed [65:0] mul;

  function automatic logic [31:0] dband(input logic signed [31:0] x, input logic [30:0] lim);
    logic [32:0] m;
    m = x[31] ? 33'(-{x[31], x}) : 33'(x);
    return (m < {2'b0, lim}) ? 32'd0 : x;
  endfunction

  function automatic logic signed [65:0] fl16(input logic signed [66:0] x);
    return 66'(x >>> 16);
  endfunction

  // Operand select for the shared multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.sel)
      4'd0: begin ma = 33'(signed'({1'b0, z})); mb = 33'(signed'({1'b0, z})); end
      4'd1: begin ma = 33'(signed'({1'b0, SIN_C_EXT})); mb = 33'(signed'({1'b0, z2})); end
      4'd2: begin ma = 33'(signed'({1'b0, t})); mb = 33'(signed'({1'b0, z2})); end
      4'd3: begin ma = 33'(signed'({1'b0, t})); mb = 33'(signed'({1'b0, z})); end
      4'd4: begin ma = 33'(trig[1]); mb = 33'(tgt_x) - 33'(meas_x); end
      4'd5: begin ma = 33'(trig[0]); mb = 33'(tgt_y) - 33'(meas_y); end
      4'd6: begin ma = 33'(trig[1]); mb = 33'(tgt_y) - 33'(meas_y); end
      4'd7: begin ma = 33'(trig[0]); mb = 33'(tgt_x) - 33'(meas_x); end
      4'd8: begin ma = 33'(gain_x); mb = 33'(ex); end
      4'd9: begin ma = 33'(v); mb = 33'(trig[3]); end
      4'd10: begin ma = 33'(v); mb = 33'(ey); end
      4'd11: begin ma = 33'(gain_y); mb = 33'(pvy); end
      4'd12: begin ma = 33'(gain_heading); mb = 33'(trig[2]); end
      4'd13: begin ma = 33'(tgt_vx); mb = 33'(tgt_vx); end
      4'd14: begin ma = 33'(tgt_vy); mb = 33'(tgt_vy); end
      default: begin ma = '0; mb = '0; end
    endcase
    mul = ma * mb;
  end

  logic [15:0] raw_ang;
  logic [13:0] rlow;
  always_comb begin
    case (cmd.sel[1:0])
      2'd0: raw_ang = meas_heading;
      2'd1: raw_ang = meas_heading + 16'd16384;
      2'd2: raw_ang = tgt_heading - meas_heading;
      default: raw_ang = tgt_heading - meas_heading + 16'd16384;
    endcase
    rlow = raw_ang[13:0];
  end

  logic [63:0] trial, root_next;
  assign trial = root + bitv;
  assign root_next = (rem >= trial) ? (root >> 1) + bitv : root >> 1;

  always_ff @(posedge clk) begin
    prod <= 67'(mul);
    if (rst) begin
      meas_x <= '0; meas_y <= '0; meas_heading <= '0;
      tgt_x <= '0; tgt_y <= '0; tgt_heading <= '0;
      tgt_vx <= '0; tgt_vy <= '0; tgt_turn <= '0;
    end else if (upd) begin
      if (in_word.kind == utc_pkg::KIND_POSE) begin
        meas_x <= in_word.pos_x; meas_y <= in_word.pos_y;
        meas_heading <= in_word.heading;
      end else if (in_word.kind == utc_pkg::KIND_TARGET) begin
        tgt_x <= in_word.pos_x; tgt_y <= in_word.pos_y;
        tgt_heading <= in_word.heading;
        tgt_vx <= dband(in_word.vel_x, db_vx);
        tgt_vy <= dband(in_word.vel_y, db_vy);
        tgt_turn <= dband(in_word.turn_rate, db_turn);
      end
    end
    case (cmd.op)
      utc_pkg::OP_LOAD: begin
        // Set up the angle for this sine evaluation.
        ang <= raw_ang;
        z <= raw_ang[14] ? {1'b0, 15'd16384 - 15'(rlow), 2'b00} : 18'({rlow, 2'b00});
        acc <= '0;
      end
      utc_pkg::OP_SIN_STEP: begin
        case (cmd.step)
          3'd1: z2 <= 18'(prod >>> 16);
          3'd2: t <= utc_pkg::SIN_B - 18'(prod >>> 16);
          3'd3: t <= utc_pkg::SIN_A - 18'(prod >>> 16);
          default: t <= 18'(prod >>> 16);
        endcase
      end
      utc_pkg::OP_SIN_SAVE:
        trig[cmd.step[1:0]] <= ang[15] ? 18'(-$signed({1'b0, t})) : 18'($signed({1'b0, t}));
      utc_pkg::OP_MUL: begin
        case (cmd.step)
          3'd0: acc <= prod;
          3'd1: acc <= acc + prod;
          3'd2: acc <= acc - prod;
          3'd3: ex <= utc_pkg::sat32(fl16(acc));
          3'd4: ey <= utc_pkg::sat32(fl16(acc));
          3'd5: pvy <= utc_pkg::sat32(fl16(prod));
          3'd6: acc <= 67'(utc_pkg::sat32(fl16(prod)));
          default: acc <= acc + 67'(utc_pkg::sat32(fl16(prod)));
        endcase
      end
      utc_pkg::OP_SQRT: begin
        if (cmd.step == 3'd0) begin
          rem <= sq; root <= '0; bitv <= 64'h4000000000000000;
        end else if (cmd.step == 3'd1) begin
          sq <= 64'(acc);
        end else begin
          if (rem >= trial)
            rem <= rem - trial;
          root <= root_next;
          bitv <= bitv >> 2;
          if (bitv == 64'd1)
            v <= (root_next[63:31] != '0) ? 32'sh7FFFFFFF : 32'(root_next);
        end
      end
      utc_pkg::OP_FINISH: begin
        res.err_x <= ex;
        res.err_y <= ey;
        res.err_heading <= tgt_heading - meas_heading;
        if (mode == utc_pkg::MODE_PASS) begin
          res.cmd_speed <= v;
          res.cmd_turn <= tgt_turn;
        end else if (cmd.step == 3'd0) begin
          res.cmd_speed <= utc_pkg::sat32(66'(acc));
        end else begin
          res.cmd_turn <= utc_pkg::sat32(66'(acc) + 66'(tgt_turn));
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/utc_control.sv
// Sequencer of the unicycle tracking controller: steps the datapath through
// sine evaluations, rotation, square root and the control law for one tick.
// Depends on utc_pkg.
module utc_control (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output utc_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {S_IDLE, S_RUN} state_t;
  state_t state;
  logic [6:0] pc;

  // Program: returns the datapath command for one program step.
  function automatic utc_pkg::dp_cmd_t prog(input logic [6:0] p);
    utc_pkg::dp_cmd_t c;
    logic [1:0] slot;
    logic [3:0] k;
    c = '{op: utc_pkg::OP_NONE, sel: 4'd0, step: 3'd0};
    if (p < 7'd40) begin
      // Four sine evaluations of ten steps each.
      slot = (p >= 7'd30) ? 2'd3 : (p >= 7'd20) ? 2'd2 : (p >= 7'd10) ? 2'd1 : 2'd0;
      k = 4'(p - 7'(slot) * 7'd10);
      case (k)
        4'd0: c = '{op: utc_pkg::OP_LOAD, sel: {2'b0, slot}, step: 3'd0};
        4'd1: c = '{op: utc_pkg::OP_NONE, sel: 4'd0, step: 3'd0};
        4'd2: c = '{op: utc_pkg::OP_SIN_STEP, sel: 4'd0, step: 3'd1};
        4'd3: c = '{op: utc_pkg::OP_NONE, sel: 4'd1, step: 3'd0};
        4'd4: c = '{op: utc_pkg::OP_SIN_STEP, sel: 4'd1, step: 3'd2};
        4'd5: c = '{op: utc_pkg::OP_NONE, sel: 4'd2, step: 3'd0};
        4'd6: c = '{op: utc_pkg::OP_SIN_STEP, sel: 4'd2, step: 3'd3};
        4'd7: c = '{op: utc_pkg::OP_NONE, sel: 4'd3, step: 3'd0};
        4'd8: c = '{op: utc_pkg::OP_SIN_STEP, sel: 4'd3, step: 3'd4};
        default: c = '{op: utc_pkg::OP_SIN_SAVE, sel: 4'd0, step: {1'b0, slot}};
      endcase
    end else begin
      case (p)
        7'd40: c = '{op: utc_pkg::OP_NONE, sel: 4'd4, step: 3'd0};
        7'd41: c = '{op: utc_pkg::OP_MUL, sel: 4'd5, step: 3'd0};
        7'd42: c = '{op: utc_pkg::OP_MUL, sel: 4'd6, step: 3'd1};
        7'd43: c = '{op: utc_pkg::OP_MUL, sel: 4'd6, step: 3'd3};
        7'd44: c = '{op: utc_pkg::OP_MUL, sel: 4'd7, step: 3'd0};
        7'd45: c = '{op: utc_pkg::OP_MUL, sel: 4'd13, step: 3'd2};
        7'd46: c = '{op: utc_pkg::OP_MUL, sel: 4'd13, step: 3'd4};
        7'd47: c = '{op: utc_pkg::OP_MUL, sel: 4'd14, step: 3'd0};
        7'd48: c = '{op: utc_pkg::OP_MUL, sel: 4'd0, step: 3'd1};
        7'd49: c = '{op: utc_pkg::OP_SQRT, sel: 4'd0, step: 3'd1};
        7'd50: c = '{op: utc_pkg::OP_SQRT, sel: 4'd0, step: 3'd0};
        7'd83: c = '{op: utc_pkg::OP_NONE, sel: 4'd8, step: 3'd0};
        7'd84: c = '{op: utc_pkg::OP_MUL, sel: 4'd9, step: 3'd6};
        7'd85: c = '{op: utc_pkg::OP_MUL, sel: 4'd10, step: 3'd7};
        7'd86: c = '{op: utc_pkg::OP_FINISH, sel: 4'd10, step: 3'd0};
        7'd87: c = '{op: utc_pkg::OP_MUL, sel: 4'd12, step: 3'd5};
        7'd88: c = '{op: utc_pkg::OP_MUL, sel: 4'd11, step: 3'd6};
        7'd89: c = '{op: utc_pkg::OP_MUL, sel: 4'd0, step: 3'd7};
        7'd90: c = '{op: utc_pkg::OP_FINISH, sel: 4'd0, step: 3'd1};
        default: begin
          // Square-root bit steps.
          if (p > 7'd50 && p < 7'd83)
            c = '{op: utc_pkg::OP_SQRT, sel: 4'd0, step: 3'd2};
        end
      endcase
    end
    return c;
  endfunction

  assign cmd = (state == S_RUN) ? prog(pc) : prog(7'd127);
  assign busy = (state == S_RUN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: if (start) begin
          state <= S_RUN;
          pc <= '0;
        end
        S_RUN: begin
          pc <= pc + 7'd1;
          if (pc == 7'd90) begin
            state <= S_IDLE;
            done <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/unicycle_tracking_controller_unit.sv
// Unicycle trajectory-tracking controller: the time from accept to a tick's
// result is set by the single shared multiplier and a one-bit-per-cycle square
// root; pose and target updates are registered on accept. Depends on utc_pkg,
// utc_control, utc_datapath.
module unicycle_tracking_controller_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  utc_pkg::in_word_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output utc_pkg::out_word_t   out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [utc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [utc_pkg::CfgDataW-1:0] cfg_value
);

  logic [1:0] mode;
  logic signed [31:0] gain_x, gain_y, gain_heading;
  logic [30:0] db_vx, db_vy, db_turn;
  logic busy, done, upd, in_acc;
  utc_pkg::dp_cmd_t cmd;
  utc_pkg::out_word_t res;

  assign cfg_ready = 1'b1;
  // The cycle of done still counts as occupied: the result word lands in out_data next.
  assign in_ready = !busy && !done && !out_valid;
  assign in_acc = in_valid && in_ready;
  assign upd = in_acc;

  logic go;
  assign go = in_acc && in_data.kind == utc_pkg::KIND_TICK && mode != utc_pkg::MODE_OFF;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= '0; gain_x <= '0; gain_y <= '0; gain_heading <= '0;
      db_vx <= '0; db_vy <= '0; db_turn <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        utc_pkg::REG_MODE: mode <= cfg_value[1:0];
        utc_pkg::REG_GAIN_X: gain_x <= cfg_value;
        utc_pkg::REG_GAIN_Y: gain_y <= cfg_value;
        utc_pkg::REG_GAIN_HEADING: gain_heading <= cfg_value;
        utc_pkg::REG_DB_VX: db_vx <= cfg_value[30:0];
        utc_pkg::REG_DB_VY: db_vy <= cfg_value[30:0];
        utc_pkg::REG_DB_TURN: db_turn <= cfg_value[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (done) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
    if (done) out_data <= res;
  end

  utc_control u_ctrl (.clk(clk), .rst(rst), .start(go), .busy(busy), .done(done),
    .cmd(cmd));

  utc_datapath u_dp (.clk(clk), .cmd(cmd), .upd(upd), .in_word(in_data), .mode(mode),
    .gain_x(gain_x), .gain_y(gain_y), .gain_heading(gain_heading), .db_vx(db_vx),
    .db_vy(db_vy), .db_turn(db_turn), .rst(rst), .res(res));

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ready) else $error("input taken while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

endmodule

### dv/tb.sv
// Self-checking testbench for unicycle_tracking_controller_unit: directed table,
// then randomized phases over all modes and idling patterns.
// Depends on utc_pkg and the controller RTL.
module tb;

  localparam int HalfPeriod = 5;
  localparam int TickLatency = 120;
  localparam int WatchdogLimit = 40000;
  localparam int ItemsPerPhase = 250;
  localparam int NumPhases = 6;

  typedef struct {
    utc_pkg::in_word_t w;
    bit typed;
    utc_pkg::out_word_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  utc_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  utc_pkg::out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [utc_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [utc_pkg::CfgDataW-1:0] cfg_value = '0;

  // Controller model state.
  logic [1:0] ctl_mode;
  longint ctl_gain_x, ctl_gain_y, ctl_gain_hd, ctl_db_vx, ctl_db_vy, ctl_db_turn;
  longint meas_x, meas_y, tgt_x, tgt_y, tgt_vx, tgt_vy, tgt_turn;
  logic [15:0] meas_hd, tgt_hd;

  utc_pkg::out_word_t cmd_q[$];
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int errors = 0;
  int cmds_checked = 0;
  int ticks_sent = 0;
  int idle_cycles = 0;

  unicycle_tracking_controller_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_value(cfg_value)
  );

  always #HalfPeriod clk = ~clk;

  function automatic longint clamp32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint mul_q16(input longint a, input longint b);
    return clamp32((a * b) >>> 16);
  endfunction

  function automatic longint sine_q16(input logic [15:0] ang);
    longint unsigned r, z, z2, t;
    r = ang[13:0];
    if (ang[14]) r = 16384 - r;
    z = r << 2;
    z2 = (z * z) >> 16;
    t = (utc_pkg::SIN_C * z2) >> 16;
    t = utc_pkg::SIN_B - t;
    t = (t * z2) >> 16;
    t = utc_pkg::SIN_A - t;
    t = (t * z) >> 16;
    return ang[15] ? -longint'(t) : longint'(t);
  endfunction

  function automatic longint cosine_q16(input logic [15:0] ang);
    return sine_q16(ang + 16'h4000);
  endfunction

  function automatic longint unsigned root64(input longint unsigned n);
    longint unsigned rem, res, bt;
    rem = n;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > rem) bt >>= 2;
    while (bt != 0) begin
      if (rem >= res + bt) begin
        rem -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic longint apply_deadband(input longint v, input longint lim);
    longint m;
    m = (v < 0) ? -v : v;
    return (m < lim) ? 0 : v;
  endfunction

  // Updates the model with one accepted word; returns 1 when a command is due.
  function automatic bit track_step(input utc_pkg::in_word_t w, output utc_pkg::out_word_t r);
    longint dx, dy, c, s, ex, ey, v, spd, trn;
    longint unsigned vr;
    logic [15:0] eh;
    r = '0;
    case (w.kind)
      utc_pkg::KIND_POSE: begin
        meas_x = w.pos_x;
        meas_y = w.pos_y;
        meas_hd = w.heading;
        return 0;
      end
      utc_pkg::KIND_TARGET: begin
        tgt_x = w.pos_x;
        tgt_y = w.pos_y;
        tgt_hd = w.heading;
        tgt_vx = apply_deadband(w.vel_x, ctl_db_vx);
        tgt_vy = apply_deadband(w.vel_y, ctl_db_vy);
        tgt_turn = apply_deadband(w.turn_rate, ctl_db_turn);
        return 0;
      end
      utc_pkg::KIND_TICK: ;
      default: return 0;
    endcase
    if (ctl_mode == utc_pkg::MODE_OFF) return 0;
    dx = tgt_x - meas_x;
    dy = tgt_y - meas_y;
    c = cosine_q16(meas_hd);
    s = sine_q16(meas_hd);
    ex = clamp32((c * dx + s * dy) >>> 16);
    ey = clamp32((c * dy - s * dx) >>> 16);
    eh = tgt_hd - meas_hd;
    vr = root64(longint'(tgt_vx * tgt_vx) + longint'(tgt_vy * tgt_vy));
    v = (vr > 64'h7FFFFFFF) ? 64'sh7FFFFFFF : longint'(vr);
    if (ctl_mode == utc_pkg::MODE_PASS) begin
      spd = v;
      trn = tgt_turn;
    end else begin
      spd = clamp32(mul_q16(ctl_gain_x, ex) + mul_q16(v, cosine_q16(eh)));
      trn = clamp32(tgt_turn + mul_q16(ctl_gain_y, mul_q16(v, ey))
                    + mul_q16(ctl_gain_hd, sine_q16(eh)));
    end
    r.cmd_speed = spd[31:0];
    r.cmd_turn = trn[31:0];
    r.err_x = ex[31:0];
    r.err_y = ey[31:0];
    r.err_heading = eh;
    return 1;
  endfunction

  function automatic utc_pkg::in_word_t make_word(input logic [1:0] kind,
                                                  input logic [31:0] px,
                                                  input logic [31:0] py,
                                                  input logic [15:0] hd,
                                                  input logic [31:0] vx,
                                                  input logic [31:0] vy,
                                                  input logic [31:0] tr);
    utc_pkg::in_word_t w;
    w.kind = kind;
    w.pos_x = px;
    w.pos_y = py;
    w.heading = hd;
    w.vel_x = vx;
    w.vel_y = vy;
    w.turn_rate = tr;
    return w;
  endfunction

  function automatic utc_pkg::out_word_t make_cmd(input logic [31:0] spd,
                                                  input logic [31:0] trn,
                                                  input logic [31:0] ex,
                                                  input logic [31:0] ey,
                                                  input logic [15:0] eh);
    utc_pkg::out_word_t r;
    r.cmd_speed = spd;
    r.cmd_turn = trn;
    r.err_x = ex;
    r.err_y = ey;
    r.err_heading = eh;
    return r;
  endfunction

  // Mostly full-range values, with extremes and small magnitudes mixed in.
  function automatic logic [31:0] pick_q16();
    case ($urandom_range(7))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2, 3: return $urandom_range(0, 32'h000FFFFF) - 32'h00080000;
      default: return $urandom;
    endcase
  endfunction

  // Velocities often sit right at or just inside a dead-band edge.
  function automatic logic [31:0] pick_vel(input longint lim);
    logic [31:0] l;
    l = lim[31:0];
    case ($urandom_range(9))
      0: return l;
      1: return -l;
      2: return l - 1;
      3: return 32'h80000000;
      4: return 1 - l;
      default: return pick_q16();
    endcase
  endfunction

  function automatic utc_pkg::in_word_t random_word();
    int k;
    k = $urandom_range(99);
    if (k < 30) return make_word(utc_pkg::KIND_POSE, pick_q16(), pick_q16(), 16'($urandom),
                                 $urandom, $urandom, $urandom);
    if (k < 60) return make_word(utc_pkg::KIND_TARGET, pick_q16(), pick_q16(), 16'($urandom),
                                 pick_vel(ctl_db_vx), pick_vel(ctl_db_vy),
                                 pick_vel(ctl_db_turn));
    if (k < 95) return make_word(utc_pkg::KIND_TICK, $urandom, $urandom, 16'($urandom),
                                 $urandom, $urandom, $urandom);
    return make_word(utc_pkg::KIND_UNUSED, $urandom, $urandom, 16'($urandom), $urandom,
                     $urandom, $urandom);
  endfunction

  task automatic write_reg(input logic [utc_pkg::CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_value <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      utc_pkg::REG_MODE: ctl_mode = val[1:0];
      utc_pkg::REG_GAIN_X: ctl_gain_x = longint'(signed'(val));
      utc_pkg::REG_GAIN_Y: ctl_gain_y = longint'(signed'(val));
      utc_pkg::REG_GAIN_HEADING: ctl_gain_hd = longint'(signed'(val));
      utc_pkg::REG_DB_VX: ctl_db_vx = val[30:0];
      utc_pkg::REG_DB_VY: ctl_db_vy = val[30:0];
      utc_pkg::REG_DB_TURN: ctl_db_turn = val[30:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_all(input logic [1:0] m, input logic [31:0] gx, input logic [31:0] gy,
                           input logic [31:0] gh, input logic [31:0] dbx,
                           input logic [31:0] dby, input logic [31:0] dbt);
    write_reg(utc_pkg::REG_MODE, {30'h2AAAAAAA, m});
    write_reg(utc_pkg::REG_GAIN_X, gx);
    write_reg(utc_pkg::REG_GAIN_Y, gy);
    write_reg(utc_pkg::REG_GAIN_HEADING, gh);
    write_reg(utc_pkg::REG_DB_VX, dbx);
    write_reg(utc_pkg::REG_DB_VY, dby);
    write_reg(utc_pkg::REG_DB_TURN, dbt);
    write_reg(utc_pkg::REG_UNUSED, $urandom);
  endtask

  // Sends one word; valid stays high between back-to-back words.
  task automatic send_word(input utc_pkg::in_word_t w, input bit typed,
                           input utc_pkg::out_word_t res);
    utc_pkg::out_word_t r;
    int gap;
    gap = 0;
    while ($urandom_range(99) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    if (w.kind == utc_pkg::KIND_TICK) ticks_sent++;
    if (track_step(w, r)) cmd_q.push_back(typed ? res : r);
  endtask

  // Holds the input off until every command is back, plus the tick latency.
  task automatic drain();
    in_valid <= 1'b0;
    while (cmd_q.size() != 0) @(posedge clk);
    repeat (TickLatency) @(posedge clk);
  endtask

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    utc_pkg::out_word_t e;
    out_ready <= ($urandom_range(99) >= out_stall_pct);
    if (!rst && out_valid && out_ready) begin
      if (cmd_q.size() == 0) begin
        $display("%0t: unexpected command word %h", $time, out_data);
        errors++;
      end else begin
        e = cmd_q.pop_front();
        check_field("cmd_speed", e.cmd_speed, out_data.cmd_speed);
        check_field("cmd_turn", e.cmd_turn, out_data.cmd_turn);
        check_field("err_x", e.err_x, out_data.err_x);
        check_field("err_y", e.err_y, out_data.err_y);
        check_field("err_heading", {16'h0, e.err_heading}, {16'h0, out_data.err_heading});
        cmds_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    ctl_mode = utc_pkg::MODE_OFF;
    ctl_gain_x = 0; ctl_gain_y = 0; ctl_gain_hd = 0;
    ctl_db_vx = 0; ctl_db_vy = 0; ctl_db_turn = 0;
    meas_x = 0; meas_y = 0; tgt_x = 0; tgt_y = 0;
    tgt_vx = 0; tgt_vy = 0; tgt_turn = 0;
    meas_hd = 0; tgt_hd = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part in pass-through mode. After reset a tick sees all-zero state.
    row.typed = 1'b1;
    row.w = make_word(utc_pkg::KIND_TICK, '0, '0, '0, '0, '0, '0);
    row.res = '0;
    rows.push_back(row);
    row.typed = 1'b0;
    row.w = make_word(utc_pkg::KIND_TARGET, 32'h00010000, '0, 16'h4000, 32'h80000000, '0,
                      32'h7FFFFFFF);
    rows.push_back(row);
    // Magnitude of the most negative speed saturates; cos(0) is exactly one.
    row.typed = 1'b1;
    row.w = make_word(utc_pkg::KIND_TICK, '0, '0, '0, '0, '0, '0);
    row.res = make_cmd(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00010000, '0, 16'h4000);
    rows.push_back(row);
    row.typed = 1'b0;
    row.w = make_word(utc_pkg::KIND_UNUSED, '1, '1, '1, '1, '1, '1);
    rows.push_back(row);
    row.w = make_word(utc_pkg::KIND_TICK, '1, '1, '1, '1, '1, '1);
    rows.push_back(row);
    row.w = make_word(utc_pkg::KIND_POSE, 32'h7FFFFFFF, 32'h80000000, 16'hFFFF, '0, '0, '0);
    rows.push_back(row);
    row.w = make_word(utc_pkg::KIND_TARGET, 32'h80000000, 32'h7FFFFFFF, '0, 32'h7FFFFFFF,
                      32'h7FFFFFFF, 32'h80000000);
    rows.push_back(row);
    row.w = make_word(utc_pkg::KIND_TICK, '0, '0, '0, '0, '0, '0);
    rows.push_back(row);
    for (int h = 0; h < 8; h++) begin
      row.w = make_word(utc_pkg::KIND_POSE, 32'hFFFF0000, 32'h00030000,
                        16'(h) * 16'h2000, '0, '0, '0);
      rows.push_back(row);
      row.w = make_word(utc_pkg::KIND_TICK, '0, '0, '0, '0, '0, '0);
      rows.push_back(row);
    end
    write_all(utc_pkg::MODE_PASS, '0, '0, '0, '0, '0, '0);
    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].res);
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      in_idle_pct = (p % 4 == 1) ? 87 : (p % 4 == 3) ? 6 : 0;
      out_stall_pct = (p % 4 == 2) ? 87 : (p % 4 == 3) ? 6 : 0;
      case (p)
        0: write_all(utc_pkg::MODE_LAW, 32'h00010000, 32'h00010000, 32'h00010000,
                     32'h00008000, 32'h00008000, 32'h00008000);
        1: write_all(utc_pkg::MODE_LAW_ALT, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                     32'hFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        2: write_all(utc_pkg::MODE_PASS, $urandom, $urandom, $urandom,
                     $urandom_range(0, 32'h20000), $urandom_range(0, 32'h20000),
                     $urandom_range(0, 32'h20000));
        3: write_all(utc_pkg::MODE_LAW, pick_q16(), pick_q16(), pick_q16(),
                     $urandom_range(0, 32'h40000), $urandom_range(0, 32'h40000),
                     $urandom_range(0, 32'h40000));
        4: write_all(utc_pkg::MODE_OFF, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom);
        default: write_all(utc_pkg::MODE_LAW, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                           '0, '0, '0);
      endcase
      for (int n = 0; n < ItemsPerPhase; n++) send_word(random_word(), 1'b0, '0);
      drain();
    end

    $display("Covered %0d ticks over all four modes and four idling patterns;", ticks_sent);
    $display("%0d command words checked, %0d mismatches.", cmds_checked, errors);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
